FILE: hdl/slo_pkg.sv
package slo_pkg;

  // Number of CORDIC rotation steps (8 to 24).
  localparam int CORDIC_STEPS = 16;

  // Shift-add multiplier operand and product widths.
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = 6;

  // CORDIC angle and coordinate widths (Q2.30 with headroom).
  localparam int ZW = 35;
  localparam int XW = 34;
  localparam int IW = 5;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [XW-1:0] CORDIC_K    = 34'sd652032874;

  // Configuration port.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 20;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SERVO_MIN    = 3'd0,
    CFG_SERVO_MAX    = 3'd1,
    CFG_INV_TIME     = 3'd2,
    CFG_RATE_LIMIT   = 3'd3,
    CFG_STEER_GAIN   = 3'd4,
    CFG_STEER_OFFSET = 3'd5,
    CFG_WHEEL_RADIUS = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE_GO,
    S_RATE_WT,
    S_INC_GO,
    S_INC_WT,
    S_ANG_GO,
    S_ANG_WT,
    S_SPD_GO,
    S_SPD_WT,
    S_CORD_WT,
    S_VX_GO,
    S_VX_WT,
    S_VY_GO,
    S_VY_WT,
    S_OUT
  } slo_state_e;

  typedef enum logic [1:0] {
    CP_IDLE,
    CP_FOLD,
    CP_ROT,
    CP_FIN
  } cord_phase_e;

  typedef struct packed {
    logic              start;
    logic [MUL_CW-1:0] nbits;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } slo_mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] product;
  } slo_mul_rsp_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [IW-1:0] i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        5'd0:  r = 35'sh03243F6A8;
        5'd1:  r = 35'sh01DAC6705;
        5'd2:  r = 35'sh00FADBAFD;
        5'd3:  r = 35'sh007F56EA7;
        5'd4:  r = 35'sh003FEAB77;
        5'd5:  r = 35'sh001FFD55C;
        5'd6:  r = 35'sh000FFFAAB;
        5'd7:  r = 35'sh0007FFF55;
        5'd8:  r = 35'sh0003FFFEB;
        5'd9:  r = 35'sh0001FFFFD;
        5'd10: r = 35'sh000100000;
        5'd11: r = 35'sh00007FFFF;
        5'd12: r = 35'sh00003FFFF;
        5'd13: r = 35'sh000020000;
        5'd14: r = 35'sh000010000;
        5'd15: r = 35'sh000008000;
        5'd16: r = 35'sh000004000;
        5'd17: r = 35'sh000002000;
        5'd18: r = 35'sh000001000;
        5'd19: r = 35'sh000000800;
        5'd20: r = 35'sh000000400;
        5'd21: r = 35'sh000000200;
        5'd22: r = 35'sh000000100;
        5'd23: r = 35'sh000000080;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: hdl/slo_if.sv
// Input item channel.
interface slo_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [31:0]        timestamp;
  logic [15:0]        servo_cmd;
  logic signed [23:0] wheel_front_left;
  logic signed [23:0] wheel_front_right;

  modport source (output valid, req_type, timestamp, servo_cmd, wheel_front_left,
                  wheel_front_right, input ready);
  modport sink (input valid, req_type, timestamp, servo_cmd, wheel_front_left,
                wheel_front_right, output ready);
endinterface

// Result item channel.
interface slo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [19:0] steer_angle;

  modport source (output valid, vel_x, vel_y, steer_angle, input ready);
  modport sink (input valid, vel_x, vel_y, steer_angle, output ready);
endinterface

FILE: hdl/steering_lag_odometry_unit.sv
// Steering-lag odometry unit.
// Input items arrive on in_i (valid/ready). A steering item (req_type 0) carries a
// timestamp and a servo command; it loads or steps the lag integrator (a step also
// updates the steering angle) and gives no result. A wheel item (req_type 1) gives
// one result on out_o with the velocity split into x and y and the current steering
// angle, once a steering item has initialized the unit; before that it is dropped.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must
// write them only while idle, as the unit does not enforce it. One item is worked on
// at a time, through a bit-serial shift-add multiplier and an iterative CORDIC.
// A loading steering item does not take the unit out of idle; a stepping one keeps
// it busy through three products of 16, 32 and 20 multiplier bits. A wheel item
// has its result after three products of 16, 32 and 32 multiplier bits, with the
// CORDIC running beside the first product.
// A result waits in the output register while the receiver stalls; the unit still
// accepts and works on the next item and holds its result back only until the
// register is free.
// Reset clears the integrator state and loads the register defaults.
module steering_lag_odometry_unit import slo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  slo_in_if.sink            in_i,
  slo_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  slo_state_e state_q, state_d;

  logic [15:0]        servo_min_q, servo_max_q, inv_time_q, rate_limit_q, radius_q;
  logic signed [19:0] gain_q, offset_q;

  logic               init_q;
  logic [31:0]        last_time_q;
  logic signed [31:0] lag_q;
  logic signed [19:0] angle_q;

  logic [23:0]        target_q;
  logic [31:0]        dt_q, p8_q;
  logic signed [24:0] sum_q;
  logic               dneg_q, neg_q;
  logic signed [32:0] speed_q;
  logic signed [31:0] vx_q, vy_q;

  logic               out_valid_q;
  logic signed [31:0] out_vx_q, out_vy_q;
  logic signed [19:0] out_ang_q;

  slo_mul_req_t mul_req;
  slo_mul_rsp_t mul_rsp;

  logic                 cord_start, cord_busy;
  logic signed [XW-1:0] cord_cos, cord_sin;

  logic        acc_in, load_step, out_free;
  logic [15:0] cmd;

  // Item acceptance and command clamp.
  assign in_i.ready = (state_q == S_IDLE);
  assign acc_in     = in_i.valid && in_i.ready;
  assign load_step  = !init_q || (in_i.timestamp < last_time_q);
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    if (in_i.servo_cmd > servo_max_q) begin
      cmd = servo_max_q;
    end else if (in_i.servo_cmd < servo_min_q) begin
      cmd = servo_min_q;
    end else begin
      cmd = in_i.servo_cmd;
    end
  end

  // Operand magnitudes for the multiplier.
  logic signed [33:0] d_full, d_mag;
  logic signed [32:0] lag_x, lag_mag;
  logic signed [20:0] gain_x, gain_mag;
  logic signed [25:0] sum_x, sum_mag;
  logic signed [33:0] spd_x, spd_mag;
  logic signed [XW:0] cos_x, cos_mag, sin_x, sin_mag;

  always_comb begin
    d_full   = $signed({10'b0, target_q}) - {{2{lag_q[31]}}, lag_q};
    d_mag    = d_full[33] ? -d_full : d_full;
    lag_x    = {lag_q[31], lag_q};
    lag_mag  = lag_x[32] ? -lag_x : lag_x;
    gain_x   = {gain_q[19], gain_q};
    gain_mag = gain_x[20] ? -gain_x : gain_x;
    sum_x    = {sum_q[24], sum_q};
    sum_mag  = sum_x[25] ? -sum_x : sum_x;
    spd_x    = {speed_q[32], speed_q};
    spd_mag  = spd_x[33] ? -spd_x : spd_x;
    cos_x    = {cord_cos[XW-1], cord_cos};
    cos_mag  = cos_x[XW] ? -cos_x : cos_x;
    sin_x    = {cord_sin[XW-1], cord_sin};
    sin_mag  = sin_x[XW] ? -sin_x : sin_x;
  end

  // Product post-processing.
  logic [48:0]        prod_r, lim_r, clamp_r;
  logic signed [45:0] lag_sum;
  logic signed [31:0] lag_sat;
  logic signed [65:0] pv, pv_r16, pv_r9, pv_r30;
  logic signed [50:0] ang_sum;
  logic signed [19:0] ang_sat;
  logic signed [35:0] v_r;
  logic signed [31:0] v_sat;

  always_comb begin
    prod_r  = mul_rsp.product[48:0];
    lim_r   = {9'b0, rate_limit_q, 24'b0};
    clamp_r = (prod_r > lim_r) ? lim_r : prod_r;

    lag_sum = dneg_q ? ({{14{lag_q[31]}}, lag_q} - $signed({2'b0, mul_rsp.product[63:20]}))
                     : ({{14{lag_q[31]}}, lag_q} + $signed({2'b0, mul_rsp.product[63:20]}));
    if (lag_sum > 46'sd2147483647) begin
      lag_sat = 32'sh7FFFFFFF;
    end else if (lag_sum < -46'sd2147483648) begin
      lag_sat = 32'sh80000000;
    end else begin
      lag_sat = lag_sum[31:0];
    end

    pv = neg_q ? -$signed({1'b0, mul_rsp.product}) : $signed({1'b0, mul_rsp.product});

    pv_r16  = pv + 66'sd32768;
    ang_sum = {pv_r16[65], $signed(pv_r16[65:16])} + {{31{offset_q[19]}}, offset_q};
    if (ang_sum > 51'sd524287) begin
      ang_sat = 20'sh7FFFF;
    end else if (ang_sum < -51'sd524288) begin
      ang_sat = 20'sh80000;
    end else begin
      ang_sat = ang_sum[19:0];
    end

    pv_r9 = pv + 66'sd256;

    pv_r30 = pv + 66'sd536870912;
    v_r    = $signed(pv_r30[65:30]);
    if (v_r > 36'sd2147483647) begin
      v_sat = 32'sh7FFFFFFF;
    end else if (v_r < -36'sd2147483648) begin
      v_sat = 32'sh80000000;
    end else begin
      v_sat = v_r[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          if (!in_i.req_type) begin
            if (!load_step) state_d = S_RATE_GO;
          end else if (init_q) begin
            state_d = S_SPD_GO;
          end
        end
      end
      S_RATE_GO: state_d = S_RATE_WT;
      S_RATE_WT: if (mul_rsp.done) state_d = S_INC_GO;
      S_INC_GO:  state_d = S_INC_WT;
      S_INC_WT:  if (mul_rsp.done) state_d = S_ANG_GO;
      S_ANG_GO:  state_d = S_ANG_WT;
      S_ANG_WT:  if (mul_rsp.done) state_d = S_IDLE;
      S_SPD_GO:  state_d = S_SPD_WT;
      S_SPD_WT:  if (mul_rsp.done) state_d = S_CORD_WT;
      S_CORD_WT: if (!cord_busy) state_d = S_VX_GO;
      S_VX_GO:   state_d = S_VX_WT;
      S_VX_WT:   if (mul_rsp.done) state_d = S_VY_GO;
      S_VY_GO:   state_d = S_VY_WT;
      S_VY_WT:   if (mul_rsp.done) state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Multiplier requests and CORDIC start.
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      S_RATE_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = d_mag[32:0];
        mul_req.b     = MUL_BW'(inv_time_q);
        mul_req.nbits = MUL_CW'(16);
      end
      S_INC_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(p8_q);
        mul_req.b     = dt_q;
        mul_req.nbits = MUL_CW'(32);
      end
      S_ANG_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = lag_mag;
        mul_req.b     = MUL_BW'(gain_mag[19:0]);
        mul_req.nbits = MUL_CW'(20);
      end
      S_SPD_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(sum_mag[24:0]);
        mul_req.b     = MUL_BW'(radius_q);
        mul_req.nbits = MUL_CW'(16);
      end
      S_VX_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = spd_mag[32:0];
        mul_req.b     = cos_mag[31:0];
        mul_req.nbits = MUL_CW'(32);
      end
      S_VY_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = spd_mag[32:0];
        mul_req.b     = sin_mag[31:0];
        mul_req.nbits = MUL_CW'(32);
      end
      default: ;
    endcase
  end

  assign cord_start = acc_in && in_i.req_type && init_q;

  // Control state, configuration and integrator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      servo_min_q  <= 16'd16640;
      servo_max_q  <= 16'd29440;
      inv_time_q   <= 16'd7314;
      rate_limit_q <= 16'd380;
      gain_q       <= -20'sd661;
      offset_q     <= 20'sd59120;
      radius_q     <= 16'd2051;
      init_q       <= 1'b0;
      last_time_q  <= '0;
      lag_q        <= '0;
      angle_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SERVO_MIN:    servo_min_q  <= cfg_wdata_i[15:0];
          CFG_SERVO_MAX:    servo_max_q  <= cfg_wdata_i[15:0];
          CFG_INV_TIME:     inv_time_q   <= cfg_wdata_i[15:0];
          CFG_RATE_LIMIT:   rate_limit_q <= cfg_wdata_i[15:0];
          CFG_STEER_GAIN:   gain_q       <= $signed(cfg_wdata_i);
          CFG_STEER_OFFSET: offset_q     <= $signed(cfg_wdata_i);
          CFG_WHEEL_RADIUS: radius_q     <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (acc_in && !in_i.req_type) begin
        last_time_q <= in_i.timestamp;
        if (load_step) begin
          lag_q  <= $signed({8'b0, cmd, 8'b0});
          init_q <= 1'b1;
        end
      end
      if (state_q == S_INC_WT && mul_rsp.done) lag_q <= lag_sat;
      if (state_q == S_ANG_WT && mul_rsp.done) angle_q <= ang_sat;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and result register.
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      target_q <= {cmd, 8'b0};
      dt_q     <= in_i.timestamp - last_time_q;
      sum_q    <= {in_i.wheel_front_left[23], in_i.wheel_front_left}
                + {in_i.wheel_front_right[23], in_i.wheel_front_right};
    end
    unique case (state_q)
      S_RATE_GO: dneg_q <= d_full[33];
      S_RATE_WT: if (mul_rsp.done) p8_q <= clamp_r[39:8];
      S_ANG_GO:  neg_q <= lag_q[31] ^ gain_q[19];
      S_SPD_GO:  neg_q <= sum_q[24];
      S_SPD_WT:  if (mul_rsp.done) speed_q <= $signed(pv_r9[41:9]);
      S_VX_GO:   neg_q <= speed_q[32] ^ cord_cos[XW-1];
      S_VX_WT:   if (mul_rsp.done) vx_q <= v_sat;
      S_VY_GO:   neg_q <= speed_q[32] ^ cord_sin[XW-1];
      S_VY_WT:   if (mul_rsp.done) vy_q <= v_sat;
      S_OUT: begin
        if (out_free) begin
          out_vx_q  <= vx_q;
          out_vy_q  <= vy_q;
          out_ang_q <= angle_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.vel_x       = out_vx_q;
  assign out_o.vel_y       = out_vy_q;
  assign out_o.steer_angle = out_ang_q;

  slo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  slo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (angle_q),
    .busy_o  (cord_busy),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

endmodule

FILE: hdl/slo_mul.sv
module slo_mul import slo_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  slo_mul_req_t req_i,
  output slo_mul_rsp_t rsp_o
);

  logic [MUL_PW-1:0] acc_q, acc_d;
  logic [MUL_AW-1:0] a_q;
  logic [MUL_BW-1:0] b_q;
  logic [MUL_CW-1:0] cnt_q;
  logic              busy_q, done_q;

  // One multiplier bit per cycle, most significant first.
  assign acc_d = {acc_q[MUL_PW-2:0], 1'b0} + (b_q[MUL_BW-1] ? MUL_PW'(a_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        acc_q  <= '0;
        a_q    <= req_i.a;
        b_q    <= req_i.b << (MUL_CW'(MUL_BW) - req_i.nbits);
        cnt_q  <= req_i.nbits;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_d;
        b_q   <= {b_q[MUL_BW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MUL_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

FILE: hdl/slo_cordic.sv
module slo_cordic import slo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [19:0]   angle_i,
  output logic                 busy_o,
  output logic signed [XW-1:0] cos_o,
  output logic signed [XW-1:0] sin_o
);

  cord_phase_e phase_q, phase_d;

  logic signed [ZW-1:0] z_q, z0, z_wrap;
  logic signed [XW-1:0] x_q, y_q, cos_q, sin_q;
  logic [IW-1:0]        i_q;
  logic                 neg_q;

  // Angle to Q2.30 and one wrap by a full turn.
  always_comb begin
    z0 = {{(ZW-34){angle_i[19]}}, angle_i, 14'b0};
    if (z0 > PI_Q30) begin
      z_wrap = z0 - TWO_PI_Q30;
    end else if (z0 < -PI_Q30) begin
      z_wrap = z0 + TWO_PI_Q30;
    end else begin
      z_wrap = z0;
    end
  end

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      CP_IDLE: if (start_i) phase_d = CP_FOLD;
      CP_FOLD: phase_d = CP_ROT;
      CP_ROT:  if (i_q == IW'(CORDIC_STEPS - 1)) phase_d = CP_FIN;
      CP_FIN:  phase_d = CP_IDLE;
      default: phase_d = CP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= CP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Rotation datapath, one step per cycle.
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      CP_IDLE: begin
        if (start_i) z_q <= z_wrap;
      end
      CP_FOLD: begin
        x_q <= CORDIC_K;
        y_q <= '0;
        i_q <= '0;
        if (z_q > HALF_PI_Q30) begin
          z_q   <= z_q - PI_Q30;
          neg_q <= 1'b1;
        end else if (z_q < -HALF_PI_Q30) begin
          z_q   <= z_q + PI_Q30;
          neg_q <= 1'b1;
        end else begin
          neg_q <= 1'b0;
        end
      end
      CP_ROT: begin
        if (!z_q[ZW-1]) begin
          x_q <= x_q - (y_q >>> i_q);
          y_q <= y_q + (x_q >>> i_q);
          z_q <= z_q - atan_q30(i_q);
        end else begin
          x_q <= x_q + (y_q >>> i_q);
          y_q <= y_q - (x_q >>> i_q);
          z_q <= z_q + atan_q30(i_q);
        end
        i_q <= i_q + 1'b1;
      end
      CP_FIN: begin
        cos_q <= neg_q ? -x_q : x_q;
        sin_q <= neg_q ? -y_q : y_q;
      end
      default: ;
    endcase
  end

  assign busy_o = (phase_q != CP_IDLE);
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule
